// ===== rtl/core/ghp_pkg.sv =====
// ghp_pkg: shared types and constants for the generational handle pool.
// Used by every module under rtl/core except ghp_ram; depends on nothing.
package ghp_pkg;

    // fixed port field widths
    localparam int CMD_W   = 2;
    localparam int INDEX_W = 8;
    localparam int GEN_W   = 16;
    // common width for generation compares (GEN_BITS tops out at 32)
    localparam int CMP_W   = 32;

    localparam int DEF_SLOT_COUNT = 256;
    localparam int DEF_GEN_BITS   = 16;

    typedef enum logic [CMD_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_LOOKUP  = 2'd2,
        OP_NONE    = 2'd3
    } ghp_op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_A_UPD,
        ST_R_CHK,
        ST_W_CHK,
        ST_W_NXT,
        ST_DONE
    } ghp_state_t;

    // controller -> datapath
    typedef struct packed {
        logic clr_wr;
        logic latch;
        logic res_fail;
        logic rd_free;
        logic rd_ref;
        logic alloc_upd;
        logic res_look;
        logic rel_start;
        logic rd_ulink;
        logic walk_adv;
        logic unlink;
        logic free_push;
        logic out_load;
    } ghp_ctl_t;

    // datapath -> controller
    typedef struct packed {
        ghp_op_t op;
        logic    clr_last;
        logic    full;
        logic    in_range;
        logic    hit;
        logic    cur_zero;
        logic    cur_match;
        logic    steps_done;
        logic    out_free;
    } ghp_sts_t;

endpackage

// ===== rtl/core/generational_handle_pool_top.sv =====
// generational_handle_pool_top: pool of slots handed out as (index, generation) handles.
// Depends on ghp_pkg, ghp_ctrl, ghp_dp (which holds the ghp_ram tables).
//
//  channel | signals                               | handshake
//  --------+---------------------------------------+------------------------
//  in      | cmd, ref_index, ref_gen               | in_valid / in_ready
//  out     | result_index, result_gen, ok,         | out_valid / out_ready
//          | used_head                             |
//
// Allocate and lookup pass from accept through ST_ISSUE and ST_A_UPD or ST_R_CHK to
// ST_DONE; a failed or out-of-range command may skip the middle state. Release also
// walks the used list: each walk step is one registered read of the used-link RAM.
// After reset a clearing pass over every slot initialises the slot tables;
// in_ready stays low until it ends. One item is in flight at a time; a result
// waiting on out_ready holds the next item in its final state only.
module generational_handle_pool_top
    import ghp_pkg::*;
#(
    parameter int SLOT_COUNT = DEF_SLOT_COUNT,
    parameter int GEN_BITS   = DEF_GEN_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [INDEX_W-1:0] ref_index,
    input  logic [GEN_W-1:0]   ref_gen,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [INDEX_W-1:0] result_index,
    output logic [GEN_W-1:0]   result_gen,
    output logic               ok,
    output logic [INDEX_W-1:0] used_head
);

    ghp_ctl_t ctl;
    ghp_sts_t sts;

    ghp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    ghp_dp #(
        .SLOT_COUNT(SLOT_COUNT),
        .GEN_BITS  (GEN_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .cmd         (cmd),
        .ref_index   (ref_index),
        .ref_gen     (ref_gen),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_index(result_index),
        .result_gen  (result_gen),
        .ok          (ok),
        .used_head   (used_head)
    );

endmodule

// ===== rtl/core/ghp_ram.sv =====
// ghp_ram: generic single-write, single-read RAM with registered read data.
// Standalone; instanced by ghp_dp for the slot status and link tables.
module ghp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/ghp_ctrl.sv =====
// ghp_ctrl: sequencing state machine for the handle pool.
// Depends on ghp_pkg; drives ghp_dp through ghp_ctl_t, reads ghp_sts_t.
module ghp_ctrl
    import ghp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  ghp_sts_t sts,
    output ghp_ctl_t ctl
);

    ghp_state_t state_reg;
    ghp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                case (sts.op)
                    OP_ALLOC:
                    begin
                        state_next = sts.full ? ST_DONE : ST_A_UPD;
                    end
                    OP_RELEASE, OP_LOOKUP:
                    begin
                        state_next = sts.in_range ? ST_R_CHK : ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_A_UPD:
            begin
                state_next = ST_DONE;
            end
            ST_R_CHK:
            begin
                if (sts.op == OP_RELEASE && sts.hit)
                begin
                    state_next = ST_W_CHK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_W_CHK:
            begin
                if (sts.cur_zero || sts.steps_done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_W_NXT;
                end
            end
            ST_W_NXT:
            begin
                state_next = sts.cur_match ? ST_DONE : ST_W_CHK;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr_wr = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                ctl.latch = in_valid;
            end
            ST_ISSUE:
            begin
                case (sts.op)
                    OP_ALLOC:
                    begin
                        ctl.res_fail = sts.full;
                        ctl.rd_free  = !sts.full;
                    end
                    OP_RELEASE, OP_LOOKUP:
                    begin
                        ctl.res_fail = !sts.in_range;
                        ctl.rd_ref   = sts.in_range;
                    end
                    default:
                    begin
                        ctl.res_fail = 1'b1;
                    end
                endcase
            end
            ST_A_UPD:
            begin
                ctl.alloc_upd = 1'b1;
            end
            ST_R_CHK:
            begin
                ctl.res_look  = 1'b1;
                ctl.rel_start = (sts.op == OP_RELEASE) && sts.hit;
            end
            ST_W_CHK:
            begin
                if (sts.cur_zero || sts.steps_done)
                begin
                    ctl.free_push = 1'b1;
                end
                else
                begin
                    ctl.rd_ulink = 1'b1;
                end
            end
            ST_W_NXT:
            begin
                if (sts.cur_match)
                begin
                    ctl.unlink    = 1'b1;
                    ctl.free_push = 1'b1;
                end
                else
                begin
                    ctl.walk_adv = 1'b1;
                end
            end
            ST_DONE:
            begin
                ctl.out_load = sts.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/ghp_dp.sv =====
// ghp_dp: handle pool datapath - list heads, walk registers, slot tables, result register.
// Depends on ghp_pkg and ghp_ram; steered by ghp_ctrl.
module ghp_dp
    import ghp_pkg::*;
#(
    parameter int SLOT_COUNT = DEF_SLOT_COUNT,
    parameter int GEN_BITS   = DEF_GEN_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ghp_ctl_t           ctl,
    output ghp_sts_t           sts,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [INDEX_W-1:0] ref_index,
    input  logic [GEN_W-1:0]   ref_gen,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [INDEX_W-1:0] result_index,
    output logic [GEN_W-1:0]   result_gen,
    output logic               ok,
    output logic [INDEX_W-1:0] used_head
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int EXT_W = IDX_W + INDEX_W;
    localparam int STEP_W = IDX_W + 1;

    // control state
    logic [IDX_W-1:0]  clr_cnt_reg;
    logic [IDX_W-1:0]  free_head_reg;
    logic [IDX_W-1:0]  used_head_reg;
    logic [IDX_W-1:0]  prev_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic [STEP_W-1:0] steps_reg;
    logic              out_valid_reg;

    // payload
    ghp_op_t            op_reg;
    logic [INDEX_W-1:0] ref_idx_reg;
    logic [GEN_W-1:0]   ref_gen_reg;
    logic [INDEX_W-1:0] res_idx_reg;
    logic [GEN_W-1:0]   res_gen_reg;
    logic               res_ok_reg;
    logic [INDEX_W-1:0] out_idx_reg;
    logic [GEN_W-1:0]   out_gen_reg;
    logic               out_ok_reg;
    logic [INDEX_W-1:0] out_head_reg;

    // slot tables
    logic                stat_we;
    logic [IDX_W-1:0]    stat_waddr;
    logic [GEN_BITS:0]   stat_wdata;
    logic                stat_re;
    logic [IDX_W-1:0]    stat_raddr;
    logic [GEN_BITS:0]   stat_rdata;
    logic                flink_we;
    logic [IDX_W-1:0]    flink_waddr;
    logic [IDX_W-1:0]    flink_wdata;
    logic [IDX_W-1:0]    flink_rdata;
    logic                ulink_we;
    logic [IDX_W-1:0]    ulink_waddr;
    logic [IDX_W-1:0]    ulink_wdata;
    logic [IDX_W-1:0]    ulink_rdata;

    logic [EXT_W-1:0]    ref_ext;
    logic [IDX_W-1:0]    ref_slot;
    logic [EXT_W-1:0]    free_ext;
    logic [EXT_W-1:0]    used_ext;
    logic                stat_used;
    logic [GEN_BITS-1:0] stat_gen;
    logic [GEN_BITS-1:0] gen_inc;
    logic [CMP_W-1:0]    stat_gen_cmp;
    logic [CMP_W-1:0]    gen_inc_cmp;
    logic                hit;
    logic                clr_last;
    logic [IDX_W-1:0]    clr_link;
    logic                out_free;

    assign ref_ext  = EXT_W'(ref_idx_reg);
    assign ref_slot = ref_ext[IDX_W-1:0];
    assign free_ext = EXT_W'(free_head_reg);
    assign used_ext = EXT_W'(used_head_reg);

    assign stat_used    = stat_rdata[GEN_BITS];
    assign stat_gen     = stat_rdata[GEN_BITS-1:0];
    assign gen_inc      = stat_gen + GEN_BITS'(1);
    assign stat_gen_cmp = CMP_W'(stat_gen);
    assign gen_inc_cmp  = CMP_W'(gen_inc);

    // valid handle: non-null slot, in use, generation matches exactly
    assign hit = (ref_slot != '0) && stat_used && (stat_gen_cmp == CMP_W'(ref_gen_reg));

    assign clr_last = (clr_cnt_reg == IDX_W'(SLOT_COUNT - 1));
    assign clr_link = clr_last ? '0 : clr_cnt_reg + IDX_W'(1);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        sts            = '0;
        sts.op         = op_reg;
        sts.clr_last   = clr_last;
        sts.full       = (free_head_reg == '0);
        sts.in_range   = (CMP_W'(ref_idx_reg) < CMP_W'(SLOT_COUNT));
        sts.hit        = hit;
        sts.cur_zero   = (cur_reg == '0);
        sts.cur_match  = (cur_reg == ref_slot);
        sts.steps_done = (steps_reg == STEP_W'(SLOT_COUNT));
        sts.out_free   = out_free;
    end

    // table port steering
    always_comb
    begin
        stat_we     = ctl.clr_wr || ctl.alloc_upd || ctl.rel_start;
        stat_waddr  = ref_slot;
        stat_wdata  = {1'b0, stat_gen};
        if (ctl.clr_wr)
        begin
            stat_waddr = clr_cnt_reg;
            stat_wdata = '0;
        end
        else if (ctl.alloc_upd)
        begin
            stat_waddr = free_head_reg;
            stat_wdata = {1'b1, gen_inc};
        end
        stat_re    = ctl.rd_free || ctl.rd_ref;
        stat_raddr = ctl.rd_free ? free_head_reg : ref_slot;

        flink_we    = ctl.clr_wr || ctl.free_push;
        flink_waddr = ctl.clr_wr ? clr_cnt_reg : ref_slot;
        flink_wdata = ctl.clr_wr ? clr_link : free_head_reg;

        // unlink past the head rewrites the predecessor's link
        ulink_we    = ctl.alloc_upd || (ctl.unlink && (prev_reg != '0));
        ulink_waddr = ctl.alloc_upd ? free_head_reg : prev_reg;
        ulink_wdata = ctl.alloc_upd ? used_head_reg : ulink_rdata;
    end

    ghp_ram #(
        .WIDTH(GEN_BITS + 1),
        .DEPTH(SLOT_COUNT)
    ) u_stat_ram (
        .clk    (clk),
        .we     (stat_we),
        .wr_addr(stat_waddr),
        .wr_data(stat_wdata),
        .re     (stat_re),
        .rd_addr(stat_raddr),
        .rd_data(stat_rdata)
    );

    ghp_ram #(
        .WIDTH(IDX_W),
        .DEPTH(SLOT_COUNT)
    ) u_flink_ram (
        .clk    (clk),
        .we     (flink_we),
        .wr_addr(flink_waddr),
        .wr_data(flink_wdata),
        .re     (ctl.rd_free),
        .rd_addr(free_head_reg),
        .rd_data(flink_rdata)
    );

    ghp_ram #(
        .WIDTH(IDX_W),
        .DEPTH(SLOT_COUNT)
    ) u_ulink_ram (
        .clk    (clk),
        .we     (ulink_we),
        .wr_addr(ulink_waddr),
        .wr_data(ulink_wdata),
        .re     (ctl.rd_ulink),
        .rd_addr(cur_reg),
        .rd_data(ulink_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            free_head_reg <= IDX_W'(1);
            used_head_reg <= '0;
            prev_reg      <= '0;
            cur_reg       <= '0;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clr_wr)
            begin
                clr_cnt_reg <= clr_link;
            end
            if (ctl.alloc_upd)
            begin
                free_head_reg <= flink_rdata;
                used_head_reg <= free_head_reg;
            end
            if (ctl.free_push)
            begin
                free_head_reg <= ref_slot;
            end
            if (ctl.unlink && (prev_reg == '0))
            begin
                used_head_reg <= ulink_rdata;
            end
            if (ctl.rel_start)
            begin
                cur_reg   <= used_head_reg;
                prev_reg  <= '0;
                steps_reg <= '0;
            end
            else if (ctl.walk_adv)
            begin
                prev_reg  <= cur_reg;
                cur_reg   <= ulink_rdata;
                steps_reg <= steps_reg + STEP_W'(1);
            end
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            op_reg      <= ghp_op_t'(cmd);
            ref_idx_reg <= ref_index;
            ref_gen_reg <= ref_gen;
        end
        if (ctl.res_fail)
        begin
            res_idx_reg <= '0;
            res_gen_reg <= '0;
            res_ok_reg  <= 1'b0;
        end
        else if (ctl.alloc_upd)
        begin
            res_idx_reg <= free_ext[INDEX_W-1:0];
            res_gen_reg <= gen_inc_cmp[GEN_W-1:0];
            res_ok_reg  <= 1'b1;
        end
        else if (ctl.res_look)
        begin
            res_idx_reg <= hit ? ref_idx_reg : '0;
            res_gen_reg <= stat_gen_cmp[GEN_W-1:0];
            res_ok_reg  <= hit;
        end
        if (ctl.out_load)
        begin
            out_idx_reg  <= res_idx_reg;
            out_gen_reg  <= res_gen_reg;
            out_ok_reg   <= res_ok_reg;
            out_head_reg <= used_ext[INDEX_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_index = out_idx_reg;
    assign result_gen   = out_gen_reg;
    assign ok           = out_ok_reg;
    assign used_head    = out_head_reg;

endmodule

// ===== rtl/core/ghp_checker.sv =====
// ghp_checker: port-level assertions for generational_handle_pool_top, with its bind.
// Depends on ghp_pkg; sees the top level's ports only.
module ghp_checker
    import ghp_pkg::*;
#(
    parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [INDEX_W-1:0] result_index,
    input logic [GEN_W-1:0]   result_gen,
    input logic               ok,
    input logic [INDEX_W-1:0] used_head
);

    // a waiting result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_index) &&
        $stable(result_gen) && $stable(ok) && $stable(used_head))
        else $error("result beat changed while stalled");

    // a failure never names a slot
    a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> result_index == '0)
        else $error("failed result carries a slot index");

    // success never names the null slot (indices fit the port)
    a_ok_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ok && (SLOT_COUNT <= 256) |-> result_index != '0)
        else $error("successful result names the null slot");

    // one item at a time: no beat taken in the cycle after one
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in progress");

endmodule

bind generational_handle_pool_top ghp_checker #(.SLOT_COUNT(SLOT_COUNT)) u_ghp_checker (.*);
